/* rtl/sedd_pkg.sv */
// Shared types and constants for the start/end delimited deframer.
`timescale 1ns / 1ps

package sedd_pkg;

    // Width of one received or emitted byte.
    localparam int unsigned BYTE_W = 8;

    // Width of the configuration register index.
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 2'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_first;  // store the opening byte at entry zero
        logic wr_next;   // append the current byte to the frame
        logic rd_first;  // fetch entry zero into the output register
        logic rd_next;   // fetch the following entry into the output register
        logic out_zero;  // drive a zero data byte for the overflow notice
    } sedd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_start;  // incoming byte equals the start byte
        logic is_end;    // incoming byte equals the end byte
        logic full;      // frame buffer holds the maximum byte count
        logic rd_last;   // the byte on the output is the final one of the frame
    } sedd_sts_t;

endpackage

/* rtl/start_end_delimiter_deframer_top.sv */
// Top level of the start/end delimited deframer: ports, controller and datapath.
// A frame's first byte appears in the cycle after its end byte is accepted.
// One input byte per cycle while hunting or collecting; readout then sends one byte
// per cycle while m_tready is high (set by the buffer's single registered read port),
// and no input is taken until the frame's last beat or the overflow notice is taken.
// Reset (aresetn, synchronous, active low) clears both delimiter registers to zero
// and returns the block to hunting for a start byte; the buffer needs no clearing.
`timescale 1ns / 1ps

module start_end_delimiter_deframer_top #(
    parameter int unsigned FRAME_MAX = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write channel.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sedd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sedd_pkg::BYTE_W-1:0]    cfg_data,
    // Received byte stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sedd_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    // Frame byte stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sedd_pkg::BYTE_W-1:0]    m_tdata,   // [7:0] frame_byte
    output logic                           m_tlast,   // last
    output logic                           m_tuser    // [0] overflow
);

    sedd_pkg::sedd_cmd_t cmd;
    sedd_pkg::sedd_sts_t sts;

    // Configuration writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    sedd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    sedd_dp #(
        .FRAME_MAX (FRAME_MAX)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata)
    );

endmodule

/* rtl/sedd_dp.sv */
// Datapath of the deframer: configuration, frame buffer, counters and output data.
`timescale 1ns / 1ps

module sedd_dp #(
    parameter int unsigned FRAME_MAX = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [sedd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sedd_pkg::BYTE_W-1:0]    cfg_data,
    input  logic [sedd_pkg::BYTE_W-1:0]    s_tdata,
    input  sedd_pkg::sedd_cmd_t            cmd,
    output sedd_pkg::sedd_sts_t            sts,
    output logic [sedd_pkg::BYTE_W-1:0]    m_tdata
);

    localparam int unsigned ADDR_W = $clog2(FRAME_MAX);
    localparam int unsigned FILL_W = $clog2(FRAME_MAX + 1);

    logic [sedd_pkg::BYTE_W-1:0] start_reg;
    logic [sedd_pkg::BYTE_W-1:0] end_reg;
    logic [FILL_W-1:0]           fill_reg;
    logic [FILL_W-1:0]           fill_next;
    logic [ADDR_W-1:0]           rd_idx_reg;
    logic [ADDR_W-1:0]           rd_idx_next;
    logic [ADDR_W-1:0]           wr_addr;
    logic [ADDR_W-1:0]           rd_addr;
    logic [sedd_pkg::BYTE_W-1:0] rd_data_reg;
    logic [sedd_pkg::BYTE_W-1:0] frame_mem [FRAME_MAX];

    // Configuration registers; writes beyond the register list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            end_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                sedd_pkg::CFG_START_BYTE: start_reg <= cfg_data;
                sedd_pkg::CFG_END_BYTE:   end_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Fill count and readout index updates.
    always_comb begin
        fill_next   = fill_reg;
        rd_idx_next = rd_idx_reg;
        if (cmd.wr_first) begin
            fill_next = FILL_W'(1);
        end else if (cmd.wr_next) begin
            fill_next = fill_reg + 1'b1;
        end
        if (cmd.rd_first) begin
            rd_idx_next = '0;
        end else if (cmd.rd_next) begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= '0;
            rd_idx_reg <= '0;
        end else begin
            fill_reg   <= fill_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    // A byte is only appended while the buffer is not full, so the count fits the address.
    assign wr_addr = cmd.wr_first ? '0 : fill_reg[ADDR_W-1:0];
    assign rd_addr = rd_idx_next;

    // Frame buffer with one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.wr_first || cmd.wr_next) begin
            frame_mem[wr_addr] <= s_tdata;
        end
        if (cmd.rd_first || cmd.rd_next) begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    // Status toward the controller.
    always_comb begin
        sts.is_start = (s_tdata == start_reg);
        sts.is_end   = (s_tdata == end_reg);
        sts.full     = (fill_reg == FILL_W'(FRAME_MAX));
        sts.rd_last  = ((FILL_W'(rd_idx_reg) + 1'b1) == fill_reg);
    end

    // The overflow notice carries a zero data byte.
    assign m_tdata = cmd.out_zero ? '0 : rd_data_reg;

endmodule

/* rtl/sedd_ctrl.sv */
// Controller state machine of the deframer: hunt, collect, readout and overflow notice.
`timescale 1ns / 1ps

module sedd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic                m_tlast,
    output logic                m_tuser,
    input  sedd_pkg::sedd_sts_t sts,
    output sedd_pkg::sedd_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_HUNT    = 4'b0001,
        ST_COLLECT = 4'b0010,
        ST_READOUT = 4'b0100,
        ST_OVF     = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_beat;
    logic   out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // Next state and datapath commands.
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.out_zero = (state_reg == ST_OVF);
        case (state_reg)
            ST_HUNT: begin
                if (in_beat && sts.is_start) begin
                    cmd.wr_first = 1'b1;
                    state_next   = ST_COLLECT;
                end
            end
            ST_COLLECT: begin
                if (in_beat) begin
                    if (sts.full) begin
                        state_next = ST_OVF;
                    end else begin
                        cmd.wr_next = 1'b1;
                        if (sts.is_end) begin
                            cmd.rd_first = 1'b1;
                            state_next   = ST_READOUT;
                        end
                    end
                end
            end
            ST_READOUT: begin
                if (out_beat) begin
                    if (sts.rd_last) begin
                        state_next = ST_HUNT;
                    end else begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            ST_OVF: begin
                if (out_beat) begin
                    state_next = ST_HUNT;
                end
            end
            default: begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Handshake outputs come straight from the state register; m_tlast also uses the last-byte status.
    assign s_tready = (state_reg == ST_HUNT) || (state_reg == ST_COLLECT);
    assign m_tvalid = (state_reg == ST_READOUT) || (state_reg == ST_OVF);
    assign m_tlast  = (state_reg == ST_OVF) || ((state_reg == ST_READOUT) && sts.rd_last);
    assign m_tuser  = (state_reg == ST_OVF);

    // Input and output sides are never open in the same cycle.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output open together");

    // A closing byte that fits starts the readout on the next cycle.
    a_end_starts_readout: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COLLECT && in_beat && !sts.full && sts.is_end)
        |=> (m_tvalid && !m_tuser))
        else $error("frame readout did not start after the end byte");

    // A byte arriving at a full buffer yields the overflow notice next.
    a_full_gives_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COLLECT && in_beat && sts.full)
        |=> (m_tvalid && m_tuser && m_tlast))
        else $error("overflow notice missing after a full buffer");

    // The final beat of a frame or notice returns the block to hunting.
    a_last_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_beat && m_tlast) |=> (state_reg == ST_HUNT))
        else $error("block did not go idle after the final beat");

endmodule
